FILE: rtl/core/csfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csfb_pkg
// Shared types and constants of the segmented CAN frame builder.
// ----------------------------------------------------------------------------
package csfb_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int NUM_BANKS   = 8;
  localparam int BANK_ROWS   = STORE_BYTES / NUM_BANKS;
  localparam int ROW_W       = $clog2(BANK_ROWS);
  localparam int BANK_SEL_W  = $clog2(NUM_BANKS);
  localparam int ADDR_W      = 12;
  localparam int BASE_W      = 13;
  localparam int FRAME_BYTES = 8;
  localparam int HDR_BYTES   = 3;

  localparam logic [7:0]  PCI_FIRST    = 8'h10;
  localparam logic [7:0]  PCI_CONSEC   = 8'h20;
  localparam logic [7:0]  PCI_FLOW     = 8'h30;
  localparam logic [11:0] SINGLE_LIMIT = 12'd8;
  localparam logic [11:0] CONSEC_BYTES = 12'd7;
  localparam logic [3:0]  DLC_FULL     = 4'd8;
  localparam logic [3:0]  DLC_FLOW     = 4'd3;

  // register index, taken from paddr[2]
  localparam logic REG_MSG_LEN = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BUILD = 2'd1,
    OP_FLOW  = 2'd2
  } csfb_op_e;

  typedef enum logic [2:0] {
    KIND_SINGLE = 3'd0,
    KIND_FIRST  = 3'd1,
    KIND_CONSEC = 3'd2,
    KIND_FLOW   = 3'd3,
    KIND_ERROR  = 3'd4
  } csfb_kind_e;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [BASE_W-1:0] rd_base;
  } csfb_store_req_t;

  typedef struct packed {
    csfb_kind_e                  kind;
    logic [3:0]                  dlc;
    logic [1:0]                  hdr_cnt;
    logic [HDR_BYTES-1:0][7:0]   hdr;
    logic [BASE_W-1:0]           base;
  } csfb_frame_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/csfb_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csfb_store
// Message byte store, eight banks interleaved by address bits [2:0], so that
// any run of eight consecutive bytes is read in a single access. Read data is
// registered and held while rd_en is low.
// ----------------------------------------------------------------------------
module csfb_store
  import csfb_pkg::*;
(
  input  wire                              clk_i,
  input  wire csfb_store_req_t             req_i,
  output logic [NUM_BANKS-1:0][7:0]        rd_data_o
);

  logic [BANK_SEL_W-1:0]          wr_bank;
  logic [ADDR_W-BANK_SEL_W-1:0]   wr_row;
  logic                           wr_in_range;

  assign wr_bank     = req_i.wr_addr[BANK_SEL_W-1:0];
  assign wr_row      = req_i.wr_addr[ADDR_W-1:BANK_SEL_W];
  assign wr_in_range = ({1'b0, req_i.wr_addr} < 13'(STORE_BYTES));

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [7:0]                     mem [BANK_ROWS];
    logic [BASE_W-BANK_SEL_W-1:0]   rd_row;
    logic                           wrap;

    // banks below the start position hold bytes of the next row
    assign wrap   = (BANK_SEL_W'(b) < req_i.rd_base[BANK_SEL_W-1:0]);
    assign rd_row = req_i.rd_base[BASE_W-1:BANK_SEL_W]
                    + {{(BASE_W-BANK_SEL_W-1){1'b0}}, wrap};

    always_ff @(posedge clk_i) begin
      if (req_i.wr_en && wr_in_range && (wr_bank == BANK_SEL_W'(b))) begin
        mem[wr_row[ROW_W-1:0]] <= req_i.wr_data;
      end
      if (req_i.rd_en) begin
        rd_data_o[b] <= mem[rd_row[ROW_W-1:0]];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/csfb_assemble.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csfb_assemble
// Rotates the bank read data into message order and lays the header and
// payload bytes into the eight frame bytes; bytes past the DLC are zero.
// ----------------------------------------------------------------------------
module csfb_assemble
  import csfb_pkg::*;
(
  input  wire csfb_frame_ctrl_t              ctrl_i,
  input  wire  [NUM_BANKS-1:0][7:0]          bank_i,
  output logic [FRAME_BYTES-1:0][7:0]        frame_o
);

  logic [NUM_BANKS-1:0][7:0] msg;

  always_comb begin
    logic [BANK_SEL_W-1:0] sel;
    logic [BASE_W:0]       abs_addr;
    for (int i = 0; i < NUM_BANKS; i++) begin
      sel      = ctrl_i.base[BANK_SEL_W-1:0] + BANK_SEL_W'(i);
      abs_addr = {1'b0, ctrl_i.base} + (BASE_W+1)'(i);
      msg[i]   = (abs_addr < (BASE_W+1)'(STORE_BYTES)) ? bank_i[sel] : 8'h00;
    end
  end

  always_comb begin
    logic [2:0] src;
    for (int j = 0; j < FRAME_BYTES; j++) begin
      src = 3'(j) - {1'b0, ctrl_i.hdr_cnt};
      if (4'(j) >= ctrl_i.dlc) begin
        frame_o[j] = 8'h00;
      end else if (3'(j) < {1'b0, ctrl_i.hdr_cnt}) begin
        frame_o[j] = ctrl_i.hdr[j[1:0]];
      end else begin
        frame_o[j] = msg[src];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/can_segment_frame_builder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_segment_frame_builder_core
// Builds single, first, consecutive and flow-control CAN frames of a
// segmented message kept in an internal byte store.
// ----------------------------------------------------------------------------
// Build and flow words pass through decode, the banked store read and frame
// assembly into the output register, in that order.
// Throughput: one word per cycle unless m_axis_tready stalls the pipeline; the
// eight-bank store delivers all message bytes of a frame in a single read.
// Write words take effect at acceptance. Reset clears the pipeline valids and
// message_length; store contents stay undefined until written (no clearing pass).
module can_segment_frame_builder_core
  import csfb_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // [11:0] buffer_address, [19:12] buffer_byte, [29:20] frame_number,
  // [33:30] flow_status, [41:34] block_size, [49:42] separation_time
  input  wire  [55:0]  s_axis_tdata,
  // [1:0] opcode
  input  wire  [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // [3:0] data_length_code, [11:4] byte_zero, [19:12] byte_one,
  // [27:20] byte_two, [35:28] byte_three, [43:36] byte_four,
  // [51:44] byte_five, [59:52] byte_six, [67:60] byte_seven
  output logic [71:0]  m_axis_tdata,
  // [2:0] frame_kind
  output logic [2:0]   m_axis_tuser,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // configuration
  logic [11:0] len_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MSG_LEN) ? {20'd0, len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 12'd0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MSG_LEN)) begin
      len_q <= pwdata[11:0];
    end
  end

  // pipeline control
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic accept;
  csfb_op_e in_op;

  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign accept        = s_axis_tvalid && rdy1;
  assign in_op         = csfb_op_e'(s_axis_tuser);

  // stage 0: start offset of the frame's payload
  logic [ADDR_W-1:0] in_addr;
  logic [7:0]        in_byte;
  logic [9:0]        in_fnum;
  logic [BASE_W-1:0] in_base;

  assign in_addr = s_axis_tdata[11:0];
  assign in_byte = s_axis_tdata[19:12];
  assign in_fnum = s_axis_tdata[29:20];
  assign in_base = (in_fnum == 10'd0) ? '0
                 : ({in_fnum, 3'b000} - {3'b000, in_fnum} - BASE_W'(1));

  logic              s1_flow_q;
  logic              s1_fzero_q;
  logic [3:0]        s1_fnib_q;
  logic [3:0]        s1_fstat_q;
  logic [7:0]        s1_bsize_q;
  logic [7:0]        s1_stime_q;
  logic [BASE_W-1:0] s1_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= accept && ((in_op == OP_BUILD) || (in_op == OP_FLOW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_flow_q  <= (in_op == OP_FLOW);
      s1_fzero_q <= (in_fnum == 10'd0);
      s1_fnib_q  <= in_fnum[3:0];
      s1_fstat_q <= s_axis_tdata[33:30];
      s1_bsize_q <= s_axis_tdata[41:34];
      s1_stime_q <= s_axis_tdata[49:42];
      s1_base_q  <= in_base;
    end
  end

  // store: writes at acceptance, reads as stage 1 moves into stage 2
  csfb_store_req_t           store_req;
  logic [NUM_BANKS-1:0][7:0] bank_data;

  always_comb begin
    store_req.wr_en   = accept && (in_op == OP_WRITE);
    store_req.wr_addr = in_addr;
    store_req.wr_data = in_byte;
    store_req.rd_en   = rdy2;
    store_req.rd_base = s1_base_q;
  end

  csfb_store u_store (
    .clk_i     (clk_i),
    .req_i     (store_req),
    .rd_data_o (bank_data)
  );

  // stage 1: frame type, DLC and header bytes
  csfb_frame_ctrl_t s1_ctrl;

  always_comb begin
    logic        len_short;
    logic [11:0] left;
    len_short = (len_q < SINGLE_LIMIT);
    left      = len_q - s1_base_q[11:0];
    s1_ctrl         = '0;
    s1_ctrl.kind    = KIND_ERROR;
    s1_ctrl.base    = s1_base_q;
    if (s1_flow_q) begin
      s1_ctrl.kind    = KIND_FLOW;
      s1_ctrl.dlc     = DLC_FLOW;
      s1_ctrl.hdr_cnt = 2'd3;
      s1_ctrl.hdr[0]  = PCI_FLOW | {4'h0, s1_fstat_q};
      s1_ctrl.hdr[1]  = s1_bsize_q;
      s1_ctrl.hdr[2]  = s1_stime_q;
    end else if (s1_fzero_q) begin
      if (len_short) begin
        s1_ctrl.kind    = KIND_SINGLE;
        s1_ctrl.dlc     = {1'b0, len_q[2:0]} + 4'd1;
        s1_ctrl.hdr_cnt = 2'd1;
        s1_ctrl.hdr[0]  = len_q[7:0];
      end else begin
        s1_ctrl.kind    = KIND_FIRST;
        s1_ctrl.dlc     = DLC_FULL;
        s1_ctrl.hdr_cnt = 2'd2;
        s1_ctrl.hdr[0]  = PCI_FIRST | {4'h0, len_q[11:8]};
        s1_ctrl.hdr[1]  = len_q[7:0];
      end
    end else if ((s1_base_q >= {1'b0, len_q}) || len_short) begin
      s1_ctrl.kind = KIND_ERROR;
    end else begin
      s1_ctrl.kind    = KIND_CONSEC;
      s1_ctrl.dlc     = (left < CONSEC_BYTES) ? ({1'b0, left[2:0]} + 4'd1) : DLC_FULL;
      s1_ctrl.hdr_cnt = 2'd1;
      s1_ctrl.hdr[0]  = PCI_CONSEC | {4'h0, s1_fnib_q};
    end
  end

  csfb_frame_ctrl_t s2_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_ctrl_q <= s1_ctrl;
    end
  end

  // stage 2: frame assembly into the output register
  logic [FRAME_BYTES-1:0][7:0] frame;

  csfb_assemble u_assemble (
    .ctrl_i  (s2_ctrl_q),
    .bank_i  (bank_data),
    .frame_o (frame)
  );

  logic [2:0]                  out_kind_q;
  logic [3:0]                  out_dlc_q;
  logic [FRAME_BYTES-1:0][7:0] out_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      out_kind_q  <= s2_ctrl_q.kind;
      out_dlc_q   <= s2_ctrl_q.dlc;
      out_frame_q <= frame;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {4'h0, out_frame_q, out_dlc_q};

  // assertions
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_op == OP_WRITE) |=> !v1_q)
    else $error("write word entered the frame pipeline");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !rdy2 |=> v2_q && $stable(s2_ctrl_q))
    else $error("stalled stage 2 word lost or changed");

  a_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_ERROR) |-> (m_axis_tdata == '0))
    else $error("error frame carries data");

  a_flow_dlc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_FLOW) |-> (m_axis_tdata[3:0] == DLC_FLOW))
    else $error("flow frame DLC wrong");

  a_dlc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (s2_ctrl_q.dlc <= DLC_FULL) && ({2'b00, s2_ctrl_q.hdr_cnt} <= s2_ctrl_q.dlc))
    else $error("header longer than frame");

endmodule
`default_nettype wire

FILE: tb/sv/tb_can_segment_frame_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_segment_frame_builder_core
// Self-checking bench for the segmented CAN frame builder. Loads message
// bytes, programs the message length over APB and builds single, first,
// consecutive, flow-control and error frames. Every frame is checked against
// a bench-side predictor under random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_can_segment_frame_builder_core;
  import csfb_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         ITEM_TARGET   = 1650;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  stime;
    logic [7:0]  bsize;
    logic [3:0]  fstat;
    logic [9:0]  fnum;
    logic [7:0]  wbyte;
    logic [11:0] addr;
  } word_t;

  typedef struct packed {
    csfb_kind_e      kind;
    logic [3:0]      dlc;
    logic [7:0][7:0] data;
  } frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [71:0] m_axis_tdata;
  wire  [2:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  can_segment_frame_builder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // bench copy of the block state
  logic [7:0]  msg_bytes [STORE_BYTES];
  bit          written [STORE_BYTES];
  logic [11:0] msg_len = '0;

  frame_t expected_frames[$];
  frame_t want;

  int  cycles = 0;
  int  mismatches = 0;
  int  frames_checked = 0;
  int  words_sent = 0;
  int  ignored_words = 0;
  int  length_writes = 0;
  int  hold_off = 0;
  int  bi;
  bit  quiet_tx = 1'b0;
  bit  quiet_rx = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d frames outstanding", $time, expected_frames.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic frame_t build_frame(word_t w);
    frame_t      f;
    int unsigned off;
    int unsigned left;
    int          i;
    f = '0;
    f.kind = KIND_ERROR;
    if (w.op == OP_FLOW) begin
      f.kind    = KIND_FLOW;
      f.dlc     = DLC_FLOW;
      f.data[0] = PCI_FLOW | {4'h0, w.fstat};
      f.data[1] = w.bsize;
      f.data[2] = w.stime;
    end else if (w.fnum == '0) begin
      if (msg_len < SINGLE_LIMIT) begin
        f.kind    = KIND_SINGLE;
        f.dlc     = msg_len[3:0] + 4'd1;
        f.data[0] = msg_len[7:0];
        for (i = 0; i < msg_len; i++) f.data[i+1] = msg_bytes[i];
      end else begin
        f.kind    = KIND_FIRST;
        f.dlc     = DLC_FULL;
        f.data[0] = PCI_FIRST + {4'h0, msg_len[11:8]};
        f.data[1] = msg_len[7:0];
        for (i = 0; i < 6; i++) f.data[i+2] = msg_bytes[i];
      end
    end else begin
      // consecutive frame n starts at message offset 7n-1
      off = int'(CONSEC_BYTES) * int'(w.fnum) - 1;
      if (off < msg_len && msg_len >= SINGLE_LIMIT) begin
        left      = msg_len - off;
        f.kind    = KIND_CONSEC;
        f.dlc     = (left < CONSEC_BYTES) ? 4'(left + 1) : DLC_FULL;
        f.data[0] = PCI_CONSEC + {4'h0, w.fnum[3:0]};
        for (i = 1; i < f.dlc; i++) f.data[i] = msg_bytes[off + i - 1];
      end
    end
    return f;
  endfunction

  function automatic word_t rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[51:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected frame: expected none, actual kind %0d dlc %0d", $time,
                 m_axis_tuser, m_axis_tdata[3:0]);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        frames_checked++;
        if (m_axis_tuser !== want.kind) begin
          $display("%0t: frame kind: expected %0d, actual %0d", $time, want.kind,
                   m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[3:0] !== want.dlc) begin
          $display("%0t: dlc: expected %0d, actual %0d", $time, want.dlc,
                   m_axis_tdata[3:0]);
          mismatches++;
        end
        for (bi = 0; bi < FRAME_BYTES; bi++) begin
          if (m_axis_tdata[4+8*bi +: 8] !== want.data[bi]) begin
            $display("%0t: frame byte %0d: expected %02h, actual %02h", $time, bi,
                     want.data[bi], m_axis_tdata[4+8*bi +: 8]);
            mismatches++;
          end
        end
      end
    end
  end

  // result side: random stall per frame, optional long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off > 0) begin
        n = hold_off;
        hold_off = 0;
      end else begin
        n = quiet_rx ? 0 : $urandom_range(0, 10);
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_word(input word_t w);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, w.stime, w.bsize, w.fstat, w.fnum, w.wbyte, w.addr};
    s_axis_tuser  <= w.op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (w.op == OP_WRITE) begin
      msg_bytes[w.addr] = w.wbyte;
      written[w.addr]   = 1'b1;
      words_sent++;
    end else if (w.op == OP_BUILD || w.op == OP_FLOW) begin
      expected_frames.push_back(build_frame(w));
      words_sent++;
    end else begin
      ignored_words++;
    end
  endtask

  task automatic send_write(input logic [11:0] addr, input logic [7:0] data);
    word_t w;
    w       = rand_word();
    w.op    = OP_WRITE;
    w.addr  = addr;
    w.wbyte = data;
    send_word(w);
  endtask

  task automatic send_flow(input logic [3:0] fstat, input logic [7:0] bsize,
                           input logic [7:0] stime);
    word_t w;
    w       = rand_word();
    w.op    = OP_FLOW;
    w.fstat = fstat;
    w.bsize = bsize;
    w.stime = stime;
    send_word(w);
  endtask

  // loads any store byte the frame will read that was never written
  task automatic send_build(input logic [9:0] fnum);
    word_t       w;
    int unsigned lo;
    int unsigned cnt;
    int unsigned a;
    lo  = 0;
    cnt = 0;
    if (fnum == '0) begin
      cnt = (msg_len < SINGLE_LIMIT) ? msg_len : 6;
    end else begin
      lo = int'(CONSEC_BYTES) * int'(fnum) - 1;
      if (lo < msg_len && msg_len >= SINGLE_LIMIT)
        cnt = (msg_len - lo < CONSEC_BYTES) ? msg_len - lo : CONSEC_BYTES;
    end
    for (a = lo; a < lo + cnt; a++)
      if (!written[a]) send_write(12'(a), 8'($urandom_range(0, 255)));
    w      = rand_word();
    w.op   = OP_BUILD;
    w.fnum = fnum;
    send_word(w);
  endtask

  task automatic send_noise();
    word_t w;
    w = rand_word();
    case ($urandom_range(0, 3))
      0: begin w.op = OP_FLOW; send_word(w); end
      1: begin w.op = OP_UNUSED; send_word(w); end
      2: begin w.op = OP_WRITE; send_word(w); end
      default: send_build(w.fnum);
    endcase
  endtask

  // stop offering words, let every frame come out, then let the pipe empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_message_length(input logic [11:0] len);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MSG_LEN, 2'b00};
    pwdata  <= {20'd0, len};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    msg_len = len;
    length_writes++;
  endtask

  task automatic test_reset_state();
    send_build(10'd0);              // length 0 after reset: one-byte single frame
    send_flow(4'h0, 8'h00, 8'h00);
    send_flow(4'hF, 8'hFF, 8'hFF);
    send_noise();
    begin : unused_op
      word_t w;
      w    = rand_word();
      w.op = OP_UNUSED;
      send_word(w);
    end
  endtask

  task automatic test_short_messages();
    send_write(12'd0, 8'hFF);
    send_write(12'd1, 8'h00);
    send_write(12'd2, 8'hA5);
    send_write(12'd3, 8'h5A);
    set_message_length(12'd7);
    send_build(10'd0);              // full single frame
    send_build(10'd1);              // offset in range but length below 8: error
    set_message_length(12'd8);
    send_build(10'd0);
    send_build(10'd1);
    send_build(10'd2);              // offset past the end
    set_message_length(12'd0);
    send_build(10'd0);
    set_message_length(12'd1);
    send_build(10'd0);
  endtask

  task automatic test_long_message();
    set_message_length(12'd4095);
    send_write(12'd4095, 8'hFF);
    send_write(12'd4094, 8'h00);
    send_build(10'd0);
    send_build(10'd585);            // last frame, one byte left
    send_build(10'd586);
    send_build(10'd16);             // sequence nibble wraps to zero
    send_build(10'd1023);
  endtask

  task automatic test_backpressure();
    int k;
    set_message_length(12'd20);
    quiet_tx = 1'b1;
    hold_off = HOLD_CYCLES;
    send_flow(4'($urandom), 8'($urandom), 8'($urandom));
    for (k = 0; k < 48; k++) begin
      if (k % 3 == 0) send_flow(4'($urandom), 8'($urandom), 8'($urandom));
      else send_build(10'($urandom_range(0, 3)));
    end
    quiet_tx = 1'b0;
  endtask

  task automatic test_random_messages();
    int unsigned len;
    int unsigned last_n;
    int          k;
    while (words_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(0, 40);
        6, 7:             len = $urandom_range(41, 300);
        8:                len = $urandom_range(301, 4095);
        default:          len = $urandom_range(0, 1) ? 4095 : 8;
      endcase
      set_message_length(12'(len));
      quiet_tx = ($urandom_range(0, 3) == 0);
      quiet_rx = ($urandom_range(0, 3) == 0);
      if (len <= 64 && $urandom_range(0, 1))
        for (k = 0; k < len; k++) send_write(12'(k), 8'($urandom_range(0, 255)));
      last_n = (len < SINGLE_LIMIT) ? 0 : len / CONSEC_BYTES;
      if (len <= 300) begin
        for (k = 0; k <= last_n + 1; k++) begin
          if ($urandom_range(0, 9) == 0) send_noise();
          send_build(10'(k));
          if ($urandom_range(0, 7) == 0)
            send_flow(4'($urandom), 8'($urandom), 8'($urandom));
        end
      end else begin
        send_build(10'd0);
        for (k = 0; k < 20; k++) begin
          if ($urandom_range(0, 9) == 0) send_noise();
          send_build(10'($urandom_range(1, last_n)));
        end
        send_build(10'(last_n));
        send_build(10'(last_n + 1));
      end
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_short_messages();
    test_long_message();
    test_backpressure();
    test_random_messages();
    drain();
    $display("%0d words sent (%0d ignored), %0d frames checked, %0d length settings",
             words_sent, ignored_words, frames_checked, length_writes);
    $display("covered single, first, consecutive, flow and error frames, lengths 0 to 4095");
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
